FILE: src/dds_pkg.sv
// Package with payload types, register indexes and constants of the velocity shaper.
`timescale 1ns / 1ps
package dds_pkg;

  typedef struct packed {
    logic signed [15:0] robot_yaw;
    logic signed [15:0] target_yaw;
    logic        [15:0] goal_distance;
    logic signed [15:0] desired_vel_x;
    logic signed [15:0] desired_vel_y;
    logic        [15:0] elapsed_time;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] linear_command;
    logic signed [15:0] angular_command;
  } out_word_t;

  localparam logic [2:0] REG_MAX_LIN  = 3'd0;
  localparam logic [2:0] REG_MAX_ANG  = 3'd1;
  localparam logic [2:0] REG_LIN_ACC  = 3'd2;
  localparam logic [2:0] REG_ANG_ACC  = 3'd3;
  localparam logic [2:0] REG_POS_TOL  = 3'd4;
  localparam logic [2:0] REG_HEAD_TOL = 3'd5;
  localparam logic [2:0] REG_GAIN     = 3'd6;
  localparam logic [2:0] REG_TIP_ERR  = 3'd7;

  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [31:0] K_Q24      = 32'sd10188014;
  localparam logic [15:0]        K_Q16      = 16'd39797;
  localparam logic [15:0]        MIN_DT     = 16'd66;

  function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0: r = 32'sd13176795;
      5'd1: r = 32'sd7778716;
      5'd2: r = 32'sd4110060;
      5'd3: r = 32'sd2086331;
      5'd4: r = 32'sd1047214;
      5'd5: r = 32'sd524117;
      5'd6: r = 32'sd262123;
      5'd7: r = 32'sd131069;
      default: r = (i < 5'd24) ? (32'sd1 <<< (5'd24 - i)) : 32'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/diff_drive_velocity_shaper.sv
// Top level of the differential-drive velocity shaper with a shared CORDIC and serial multiplier.
// Channel | Direction | Handshake                 | Word
// in      | input     | in_valid_i / in_stall_o   | dds_pkg::in_word_t
// out     | output    | out_valid_o / out_stall_i | dds_pkg::out_word_t
// cfg     | input     | cfg_we_i, cfg_index_i     | 16-bit write data
// With the cosine slowdown, a word runs a vectoring CORDIC pass, the magnitude and gain
// multiplications, a rotation CORDIC pass, the slowdown and two acceleration multiplications;
// turn in place skips the rotation pass and slowdown, and the goal branch goes straight out.
// The next word is accepted in the cycle after the result is registered.
// Reset restores the register defaults and clears the previous commands.
// A finished result waits in the output register while the next word is accepted, and a
// stalled output holds the block and its input stall until the output register frees up.
`timescale 1ns / 1ps
module diff_drive_velocity_shaper #(
  parameter int COS_SLOWDOWN = 1,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dds_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dds_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import dds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_VEC, S_MAG, S_GAIN, S_COSI, S_COS, S_SLOW, S_SCALE, S_DV, S_DW, S_FIN,
    S_OUT
  } state_e;

  localparam int SW = 5;

  state_e state_q;
  logic [14:0] max_lin_q, max_ang_q, lin_acc_q, ang_acc_q, head_tol_q, tip_err_q;
  logic [15:0] pos_tol_q, gain_q;
  logic signed [15:0] prev_lin_q, prev_ang_q;
  in_word_t in_q;
  logic signed [31:0] x_q, y_q, z_q;
  logic [SW-1:0] it_q;
  logic signed [17:0] dy_q;
  logic signed [31:0] mag_q, lin_q, ang_q, dv_q;
  logic out_valid_q;
  out_word_t out_q;

  // Serial multiplier: unsigned 32 x 16, one multiplier bit per cycle.
  logic [47:0] ma_q;
  logic [15:0] mb_q;
  logic [47:0] acc_q;
  logic [4:0]  mc_q;

  logic signed [31:0] xs, ys;
  logic signed [17:0] wr_a, wr_b, vdir;
  logic signed [17:0] dg, adg;
  logic signed [31:0] rnd;

  function automatic logic signed [17:0] wrap(input logic signed [17:0] d);
    logic signed [17:0] r;
    r = d;
    if (r > PI_Q13) r = r - TWO_PI_Q13;
    else if (r < -PI_Q13) r = r + TWO_PI_Q13;
    return r;
  endfunction

  function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
      input logic signed [31:0] lo, input logic signed [31:0] hi);
    logic signed [31:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  assign rnd = z_q + 32'sd1024;
  assign vdir = 18'(rnd >>> 11);
  assign wr_a = wrap(18'(in_q.target_yaw) - 18'(in_q.robot_yaw));
  assign wr_b = wrap(vdir - 18'(in_q.robot_yaw));
  assign dg = wr_a;
  assign adg = dg[17] ? -dg : dg;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  logic last_it;
  assign last_it = (32'(it_q) == CORDIC_STEPS - 1) || (it_q == SW'(23));

  logic signed [31:0] eff_dt;
  logic signed [31:0] mlin, mang, dvn;
  assign eff_dt = (in_q.elapsed_time < MIN_DT) ? 32'(MIN_DT) : 32'(in_q.elapsed_time);
  assign mlin = 32'(max_lin_q);
  assign mang = 32'(max_ang_q);
  assign dvn = 32'(acc_q >> 16);

  logic signed [17:0] ady;
  assign ady = dy_q[17] ? -dy_q : dy_q;
  logic signed [47:0] gprod;
  assign gprod = dy_q[17] ? -$signed(acc_q) : $signed(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      max_lin_q  <= 15'd3277;
      max_ang_q  <= 15'd8192;
      lin_acc_q  <= 15'd4096;
      ang_acc_q  <= 15'd16384;
      pos_tol_q  <= 16'd819;
      head_tol_q <= 15'd1638;
      gain_q     <= 16'd8192;
      tip_err_q  <= 15'd9830;
      prev_lin_q <= '0;
      prev_ang_q <= '0;
      out_valid_q <= 1'b0;
      mc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_MAX_LIN:  max_lin_q  <= cfg_data_i[14:0];
          REG_MAX_ANG:  max_ang_q  <= cfg_data_i[14:0];
          REG_LIN_ACC:  lin_acc_q  <= cfg_data_i[14:0];
          REG_ANG_ACC:  ang_acc_q  <= cfg_data_i[14:0];
          REG_POS_TOL:  pos_tol_q  <= cfg_data_i;
          REG_HEAD_TOL: head_tol_q <= cfg_data_i[14:0];
          REG_GAIN:     gain_q     <= cfg_data_i;
          REG_TIP_ERR:  tip_err_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      if (mc_q != 5'd0 && state_q != S_IDLE) begin
        if (mb_q[0]) acc_q <= acc_q + ma_q;
        ma_q <= ma_q << 1;
        mb_q <= mb_q >> 1;
        mc_q <= mc_q - 5'd1;
      end
      unique case (state_q)
        S_IDLE: begin
          mc_q <= '0;
          if (in_valid_i) begin
            in_q <= in_data_i;
            state_q <= S_PRE;
          end
        end
        S_PRE: begin
          lin_q <= '0;
          ang_q <= '0;
          it_q  <= '0;
          if (in_q.goal_distance <= pos_tol_q) begin
            if (adg > 18'(head_tol_q)) ang_q <= clampv(32'(dg), -mang, mang);
            state_q <= S_OUT;
          end else if (in_q.desired_vel_x == 16'sd0 && in_q.desired_vel_y == 16'sd0) begin
            x_q <= '0; y_q <= '0; z_q <= '0;
            state_q <= S_MAG;
          end else begin
            if (in_q.desired_vel_x < 0) begin
              if (in_q.desired_vel_y >= 0) begin
                x_q <= 32'(in_q.desired_vel_y) <<< 8;
                y_q <= -(32'(in_q.desired_vel_x) <<< 8);
                z_q <= HALF_PI_Q24;
              end else begin
                x_q <= -(32'(in_q.desired_vel_y) <<< 8);
                y_q <= 32'(in_q.desired_vel_x) <<< 8;
                z_q <= -HALF_PI_Q24;
              end
            end else begin
              x_q <= 32'(in_q.desired_vel_x) <<< 8;
              y_q <= 32'(in_q.desired_vel_y) <<< 8;
              z_q <= '0;
            end
            state_q <= S_VEC;
          end
        end
        S_VEC: begin
          if (!y_q[31]) begin
            x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_q24(5'(it_q));
          end else begin
            x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_q24(5'(it_q));
          end
          it_q <= it_q + SW'(1);
          if (last_it) state_q <= S_MAG;
        end
        S_MAG: begin
          dy_q <= wr_b;
          ma_q <= 48'(x_q);
          mb_q <= K_Q16;
          acc_q <= '0;
          mc_q <= 5'd16;
          state_q <= S_GAIN;
        end
        S_GAIN: begin
          if (mc_q == 5'd0) begin
            mag_q <= 32'((acc_q + 48'd8388608) >> 24);
            ma_q <= 48'(ady);
            mb_q <= gain_q;
            acc_q <= '0;
            mc_q <= 5'd16;
            state_q <= S_COSI;
          end
        end
        S_COSI: begin
          if (mc_q == 5'd0) begin
            ang_q <= clampv(32'((gprod + 48'sd2048) >>> 12), -mang, mang);
            x_q <= K_Q24; y_q <= '0; z_q <= 32'(dy_q) <<< 11;
            it_q <= '0;
            if (ady > 18'(tip_err_q)) state_q <= S_DV;
            else if (COS_SLOWDOWN == 0) begin
              lin_q <= (mag_q < mlin) ? mag_q : mlin;
              state_q <= S_DV;
            end else if (ady > 18'sd12867) state_q <= S_DV;
            else state_q <= S_COS;
          end
        end
        S_COS: begin
          if (!z_q[31]) begin
            x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_q24(5'(it_q));
          end else begin
            x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_q24(5'(it_q));
          end
          it_q <= it_q + SW'(1);
          if (last_it) state_q <= S_SLOW;
        end
        S_SLOW: begin
          ma_q <= 48'(clampv(x_q, 32'sd0, 32'sd16777216));
          mb_q <= 16'((mag_q < mlin) ? mag_q : mlin);
          acc_q <= '0;
          mc_q <= 5'd16;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          if (mc_q == 5'd0) begin
            lin_q <= clampv(32'(acc_q >> 24), 32'sd0, mlin);
            state_q <= S_DV;
          end
        end
        S_DV: begin
          if (mc_q == 5'd0) begin
            ma_q <= 48'(lin_acc_q);
            mb_q <= 16'(eff_dt);
            acc_q <= '0;
            mc_q <= 5'd16;
            state_q <= S_DW;
          end
        end
        S_DW: begin
          if (mc_q == 5'd0) begin
            dv_q <= dvn;
            ma_q <= 48'(ang_acc_q);
            mb_q <= 16'(eff_dt);
            acc_q <= '0;
            mc_q <= 5'd16;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (mc_q == 5'd0) begin
            lin_q <= clampv(clampv(lin_q, 32'(prev_lin_q) - dv_q, 32'(prev_lin_q) + dv_q),
                            -mlin, mlin);
            ang_q <= clampv(clampv(ang_q, 32'(prev_ang_q) - dvn, 32'(prev_ang_q) + dvn),
                            -mang, mang);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.linear_command  <= 16'(lin_q);
            out_q.angular_command <= 16'(ang_q);
            prev_lin_q  <= 16'(lin_q);
            prev_ang_q  <= 16'(ang_q);
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_PRE)
    else $error("accepted word not started");
  a_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> prev_lin_q == out_data_o.linear_command)
    else $error("previous command not tracked");

endmodule
